[rtl/core/modular_arithmetic_unit_macros.svh]
// Assertion macros shared by the modular arithmetic unit RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mau_pkg.sv]
// Shared types, widths and codes of the modular arithmetic unit.
// Depends on nothing; used by mau_mulmod and modular_arithmetic_unit.
package mau_pkg;

	localparam int RESIDUE_WIDTH   = 30;
	localparam int EXPONENT_WIDTH  = 64;
	localparam int OPERAND_B_WIDTH = 63;
	localparam int ACTION_WIDTH    = 3;
	localparam int PADDR_WIDTH     = 3;
	localparam int PDATA_WIDTH     = 32;

	localparam logic [RESIDUE_WIDTH-1:0] MODULUS_RESET = RESIDUE_WIDTH'(998244353);

	// register index, taken from paddr above the byte lane bits
	localparam logic [PADDR_WIDTH-3:0] REG_MODULUS = '0;

	// action codes
	localparam logic [ACTION_WIDTH-1:0] ACT_ADD = 3'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_SUB = 3'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_MUL = 3'd2;
	localparam logic [ACTION_WIDTH-1:0] ACT_DIV = 3'd3;
	localparam logic [ACTION_WIDTH-1:0] ACT_POW = 3'd4;
	localparam logic [ACTION_WIDTH-1:0] ACT_REM = 3'd5;

	typedef struct packed {
		logic [ACTION_WIDTH-1:0]    action;
		logic [RESIDUE_WIDTH-1:0]   operand_a;
		logic [OPERAND_B_WIDTH-1:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic [RESIDUE_WIDTH-1:0] result;
		logic                     divide_by_zero;
	} out_word_t;

	// request to the bit-serial modular multiplier
	typedef struct packed {
		logic                     start;
		logic [RESIDUE_WIDTH-1:0] x;
		logic [RESIDUE_WIDTH-1:0] y;
	} mul_req_t;

	// status and product of the modular multiplier
	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic [RESIDUE_WIDTH-1:0] product;
	} mul_rsp_t;

endpackage

[rtl/core/mau_mulmod.sv]
// Bit-serial modular multiplier: x * y mod m, one bit of y per cycle, MSB first.
// Depends on mau_pkg; instantiated by modular_arithmetic_unit.
module mau_mulmod (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mau_pkg::mul_req_t                   req,
	input  logic [mau_pkg::RESIDUE_WIDTH-1:0]   modulus,
	output mau_pkg::mul_rsp_t                   rsp
);

	localparam int RW = mau_pkg::RESIDUE_WIDTH;
	localparam int CW = $clog2(RW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] x_q;
	logic [RW-1:0] ysh_q;
	logic [RW-1:0] acc_q;

	logic [RW:0]   mod_ext;
	logic [RW:0]   dbl;
	logic [RW:0]   dbl_r;
	logic [RW:0]   sum;
	logic [RW:0]   sum_r;

	// double the accumulator, fold once, add x when the bit is set, fold again
	assign mod_ext = {1'b0, modulus};
	assign dbl     = {acc_q, 1'b0};
	assign dbl_r   = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
	assign sum     = {1'b0, dbl_r[RW-1:0]} + (ysh_q[RW-1] ? {1'b0, x_q} : '0);
	assign sum_r   = (sum >= mod_ext) ? sum - mod_ext : sum;

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// operand and accumulator shift path
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.x;
			ysh_q <= req.y;
			acc_q <= '0;
		end else if (busy_q) begin
			ysh_q <= ysh_q << 1;
			acc_q <= sum_r[RW-1:0];
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

[rtl/core/modular_arithmetic_unit.sv]
// Modular ALU: add, sub, mul, Fermat division, power and plain remainder over modulus m.
// Depends on mau_pkg, mau_mulmod and modular_arithmetic_unit_macros.svh.
//
//  channel | handshake                  | word
//  --------+----------------------------+---------------------------------------
//  in      | in_valid / in_ready        | in_word_t: action, operand_a, operand_b
//  out     | out_valid / out_ready      | out_word_t: result, divide_by_zero
//  cfg     | psel/penable/pwrite/pready | modulus at byte address 0
//
// Operands are reduced bit-serially: a mod m first, then b mod m for add, sub, mul and
// div. Add and sub then finish on the reduced residues; mul adds one multiplier pass.
// Pow and div run square-and-multiply on the one shared multiplier.
// One item at a time; the next word is taken while a result waits at the output.
// Reset restores the modulus and clears the state and out_valid; there is no clearing pass.
`include "modular_arithmetic_unit_macros.svh"

module modular_arithmetic_unit #(
	parameter int EXP_WIDTH = mau_pkg::EXPONENT_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  mau_pkg::in_word_t                   in_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mau_pkg::out_word_t                  out_word,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mau_pkg::PADDR_WIDTH-1:0]     paddr,
	input  logic [mau_pkg::PDATA_WIDTH-1:0]     pwdata,
	output logic [mau_pkg::PDATA_WIDTH-1:0]     prdata,
	output logic                                pready
);

	localparam int RW   = mau_pkg::RESIDUE_WIDTH;
	localparam int BW   = mau_pkg::OPERAND_B_WIDTH;
	localparam int EW_I = (EXP_WIDTH < BW) ? EXP_WIDTH : BW;
	localparam int XW   = (EW_I > RW) ? EW_I : RW;
	localparam int CW   = $clog2(BW);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RED_A    = 4'd1;
	localparam logic [3:0] S_RED_B    = 4'd2;
	localparam logic [3:0] S_REM      = 4'd3;
	localparam logic [3:0] S_DISPATCH = 4'd4;
	localparam logic [3:0] S_MUL      = 4'd5;
	localparam logic [3:0] S_POW_CHK  = 4'd6;
	localparam logic [3:0] S_POW_MA   = 4'd7;
	localparam logic [3:0] S_POW_SQ   = 4'd8;
	localparam logic [3:0] S_FINISH   = 4'd9;

	localparam logic [RW-1:0] RES_ONE = RW'(1);
	localparam logic [RW-1:0] MOD_MIN = RW'(2);

	// control state
	logic [3:0]                        state_q, state_d;
	logic [RW-1:0]                     modulus_q;
	logic                              out_valid_q;
	logic                              out_load;
	mau_pkg::out_word_t                out_word_q;

	// operand and work registers
	logic [mau_pkg::ACTION_WIDTH-1:0]  action_q, action_d;
	logic [BW-1:0]                     b_q, b_d;
	logic [BW-1:0]                     sh_q, sh_d;
	logic [CW-1:0]                     cnt_q, cnt_d;
	logic [RW-1:0]                     rem_q, rem_d;
	logic [RW-1:0]                     ar_q, ar_d;
	logic [RW-1:0]                     br_q, br_d;
	logic [RW-1:0]                     base_q, base_d;
	logic [RW-1:0]                     acc_q, acc_d;
	logic [XW-1:0]                     exp_q, exp_d;
	logic [RW-1:0]                     res_q, res_d;
	logic                              dbz_q, dbz_d;

	// datapath wires
	logic [RW-1:0]                     div_sel;
	logic                              div_big;
	logic [RW:0]                       red_t;
	logic [RW:0]                       red_diff;
	logic [RW-1:0]                     red_nxt;
	logic [RW:0]                       add_s;
	logic [RW:0]                       add_r;
	logic [RW-1:0]                     sub_r;
	logic                              cfg_write;

	mau_pkg::mul_req_t                 mul_req;
	mau_pkg::mul_rsp_t                 mul_rsp;

	mau_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.modulus (modulus_q),
		.rsp     (mul_rsp)
	);

	// configuration port
	assign cfg_write = psel & penable & pwrite & pready
		& (paddr[mau_pkg::PADDR_WIDTH-1:2] == mau_pkg::REG_MODULUS);
	assign pready    = 1'b1;
	assign prdata    = (paddr[mau_pkg::PADDR_WIDTH-1:2] == mau_pkg::REG_MODULUS)
		? mau_pkg::PDATA_WIDTH'(modulus_q) : '0;

	// restoring remainder step: divisor is m, or b for the remainder action
	assign div_sel  = (state_q == S_REM) ? b_q[RW-1:0] : modulus_q;
	assign div_big  = (state_q == S_REM) && (|b_q[BW-1:RW]);
	assign red_t    = {rem_q, sh_q[BW-1]};
	assign red_diff = red_t - {1'b0, div_sel};
	assign red_nxt  = (!div_big && (red_t >= {1'b0, div_sel}))
		? red_diff[RW-1:0] : red_t[RW-1:0];

	// combinational add and sub on reduced residues
	assign add_s = {1'b0, ar_q} + {1'b0, br_q};
	assign add_r = (add_s >= {1'b0, modulus_q}) ? add_s - {1'b0, modulus_q} : add_s;
	assign sub_r = ar_q - br_q + ((ar_q < br_q) ? modulus_q : '0);

	// multiplier requests
	always_comb begin
		mul_req = '0;
		unique case (state_q)
			S_DISPATCH: begin
				if (action_q == mau_pkg::ACT_MUL) begin
					mul_req.start = 1'b1;
					mul_req.x     = ar_q;
					mul_req.y     = br_q;
				end
			end
			S_POW_CHK: begin
				if (exp_q == '0) begin
					if (action_q == mau_pkg::ACT_DIV) begin
						mul_req.start = 1'b1;
						mul_req.x     = ar_q;
						mul_req.y     = acc_q;
					end
				end else begin
					mul_req.start = 1'b1;
					mul_req.x     = exp_q[0] ? acc_q : base_q;
					mul_req.y     = base_q;
				end
			end
			S_POW_MA: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.x     = base_q;
					mul_req.y     = base_q;
				end
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		action_d = action_q;
		b_d      = b_q;
		sh_d     = sh_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		ar_d     = ar_q;
		br_d     = br_q;
		base_d   = base_q;
		acc_d    = acc_q;
		exp_d    = exp_q;
		res_d    = res_q;
		dbz_d    = dbz_q;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					action_d = in_word.action;
					b_d      = in_word.operand_b;
					sh_d     = {in_word.operand_a, {(BW-RW){1'b0}}};
					cnt_d    = CW'(RW - 1);
					rem_d    = '0;
					res_d    = '0;
					dbz_d    = 1'b0;
					if (modulus_q < MOD_MIN) begin
						dbz_d   = (in_word.action == mau_pkg::ACT_REM)
							&& (in_word.operand_b == '0);
						state_d = S_FINISH;
					end else begin
						state_d = S_RED_A;
					end
				end
			end
			S_RED_A: begin
				sh_d  = sh_q << 1;
				rem_d = red_nxt;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					ar_d  = red_nxt;
					rem_d = '0;
					unique case (action_q)
						mau_pkg::ACT_ADD, mau_pkg::ACT_SUB,
						mau_pkg::ACT_MUL, mau_pkg::ACT_DIV: begin
							sh_d    = b_q;
							cnt_d   = CW'(BW - 1);
							state_d = S_RED_B;
						end
						mau_pkg::ACT_POW: begin
							base_d  = red_nxt;
							acc_d   = RES_ONE;
							exp_d   = XW'(b_q[EW_I-1:0]);
							state_d = S_POW_CHK;
						end
						mau_pkg::ACT_REM: begin
							if (b_q == '0) begin
								dbz_d   = 1'b1;
								state_d = S_FINISH;
							end else begin
								sh_d    = {red_nxt, {(BW-RW){1'b0}}};
								cnt_d   = CW'(RW - 1);
								state_d = S_REM;
							end
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_RED_B: begin
				sh_d  = sh_q << 1;
				rem_d = red_nxt;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					br_d    = red_nxt;
					state_d = S_DISPATCH;
				end
			end
			S_REM: begin
				sh_d  = sh_q << 1;
				rem_d = red_nxt;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					res_d   = red_nxt;
					state_d = S_FINISH;
				end
			end
			S_DISPATCH: begin
				unique case (action_q)
					mau_pkg::ACT_ADD: begin
						res_d   = add_r[RW-1:0];
						state_d = S_FINISH;
					end
					mau_pkg::ACT_SUB: begin
						res_d   = sub_r;
						state_d = S_FINISH;
					end
					mau_pkg::ACT_MUL: begin
						state_d = S_MUL;
					end
					mau_pkg::ACT_DIV: begin
						// Fermat inverse: b^(m-2)
						base_d  = br_q;
						acc_d   = RES_ONE;
						exp_d   = XW'(modulus_q) - XW'(2);
						state_d = S_POW_CHK;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_MUL: begin
				if (mul_rsp.done) begin
					res_d   = mul_rsp.product;
					state_d = S_FINISH;
				end
			end
			S_POW_CHK: begin
				if (exp_q == '0) begin
					if (action_q == mau_pkg::ACT_DIV) begin
						state_d = S_MUL;
					end else begin
						res_d   = acc_q;
						state_d = S_FINISH;
					end
				end else if (exp_q[0]) begin
					state_d = S_POW_MA;
				end else begin
					state_d = S_POW_SQ;
				end
			end
			S_POW_MA: begin
				if (mul_rsp.done) begin
					acc_d   = mul_rsp.product;
					state_d = S_POW_SQ;
				end
			end
			S_POW_SQ: begin
				if (mul_rsp.done) begin
					base_d  = mul_rsp.product;
					exp_d   = exp_q >> 1;
					state_d = S_POW_CHK;
				end
			end
			S_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			modulus_q   <= mau_pkg::MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				modulus_q <= pwdata[RW-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		action_q <= action_d;
		b_q      <= b_d;
		sh_q     <= sh_d;
		cnt_q    <= cnt_d;
		rem_q    <= rem_d;
		ar_q     <= ar_d;
		br_q     <= br_d;
		base_q   <= base_d;
		acc_q    <= acc_d;
		exp_q    <= exp_d;
		res_q    <= res_d;
		dbz_q    <= dbz_d;
		if (out_load) begin
			out_word_q.result         <= res_q;
			out_word_q.divide_by_zero <= dbz_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// checks
	`MAU_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_valid && in_ready,
		state_q != S_IDLE, "accepted word left the sequencer idle")
	`MAU_ASSERT_NOW(a_mul_start_free, clk, arst_n, mul_req.start, !mul_rsp.busy,
		"multiplier started while busy")
	`MAU_ASSERT_NOW(a_dbz_only_rem, clk, arst_n, (state_q == S_FINISH) && dbz_q,
		action_q == mau_pkg::ACT_REM, "divide_by_zero raised outside remainder")
	`MAU_ASSERT_NOW(a_result_reduced, clk, arst_n,
		(state_q == S_FINISH) && (modulus_q >= MOD_MIN), res_q < modulus_q,
		"result not below modulus")
	`MAU_ASSERT_NOW(a_pow_reduced, clk, arst_n,
		(state_q == S_POW_CHK) || (state_q == S_POW_MA) || (state_q == S_POW_SQ),
		(acc_q < modulus_q) && (base_q < modulus_q), "power operands not reduced")

endmodule
